FILE: rtl/bis_pkg.sv
// bis_pkg: shared constants, codes and types for the bilinear image sampler
// no dependencies; imported by every module of the block

package bis_pkg;

	// fixed field widths
	localparam int ADDR_BITS      = 16;
	localparam int VALUE_BITS     = 16;
	localparam int COORD_BITS     = 18;
	localparam int FRAC_BITS      = 16;
	localparam int RESULT_BITS    = 32;
	localparam int CFG_BITS       = 9;
	localparam int CFG_INDEX_BITS = 1;
	localparam int STORE_DEPTH    = 1 << ADDR_BITS;

	// parameter defaults
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_PIXEL_BITS = 16;

	// queue sizes
	localparam int CMD_DEPTH   = 4;
	localparam int OUT_DEPTH   = 2;
	localparam int CREDIT_BITS = $clog2(OUT_DEPTH + 1);

	// configuration register reset and indexes
	localparam logic [CFG_BITS-1:0]       CFG_SIZE_RESET = 9'd256;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH      = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT     = 1'b1;

	// request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// command kinds between front and back
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_ZERO  = 2'd2;

	typedef struct packed {
		logic [1:0]           kind;
		logic [ADDR_BITS-1:0] addr0;   // write address, or base of upper row
		logic [ADDR_BITS-1:0] addr1;   // base of lower row
		logic [ADDR_BITS-1:0] col0;
		logic [ADDR_BITS-1:0] col1;
		logic [VALUE_BITS-1:0] data;
		logic [FRAC_BITS-1:0] frac_x;
		logic [FRAC_BITS-1:0] frac_y;
	} cmd_t;

	typedef struct packed {
		logic                   busy;
		logic                   pop;
		logic                   overflow;
		logic [CREDIT_BITS-1:0] credits;
	} bis_status_t;

endpackage

FILE: rtl/bis_queue.sv
// bis_queue: small register fifo with valid/ready on both sides
// depends on bis_pkg for default sizes

module bis_queue import bis_pkg::*; #(
	parameter int DATA_BITS = RESULT_BITS + 1,
	parameter int DEPTH     = CMD_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output logic [DATA_BITS-1:0] pop_data
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] slot_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 push, pop;

	assign push_ready = (count_q < CNT_BITS'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_BITS'(1);
				2'b01:   count_q <= count_q - CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/bis_front.sv
// bis_front: accepts requests, scales coordinates and builds back-end commands
// depends on bis_pkg (cmd_t, codes, field widths)

module bis_front import bis_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [CFG_BITS-1:0]          image_width,
	input  logic [CFG_BITS-1:0]          image_height,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         opcode,
	input  logic [ADDR_BITS-1:0]         pixel_address,
	input  logic [VALUE_BITS-1:0]        pixel_value,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         cmd_valid,
	input  logic                         cmd_ready,
	output cmd_t                         cmd
);

	localparam int WB   = $clog2(MAX_WIDTH + 1);
	localparam int HB   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPW = (CFG_BITS > WB) ? CFG_BITS : WB;
	localparam int CMPH = (CFG_BITS > HB) ? CFG_BITS : HB;
	localparam int XB   = FRAC_BITS + WB;
	localparam int YB   = FRAC_BITS + HB;
	localparam int RB   = HB + WB;

	logic [WB-1:0] w_eff;
	logic [HB-1:0] h_eff;
	logic          inr;
	logic [XB-1:0] xs_prod;
	logic [YB-1:0] ys_prod;

	logic                  valid_s1;
	logic                  op_s1;
	logic                  inr_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic [VALUE_BITS-1:0] data_s1;
	logic [XB-1:0]         xs_s1;
	logic [YB-1:0]         ys_s1;

	logic [WB-1:0]        c0, c0p1, c1;
	logic [HB-1:0]        r0, r0p1;
	logic [RB-1:0]        base_prod;
	logic [ADDR_BITS-1:0] base0, base1;

	// size registers limited to 1..max
	always_comb begin
		if (image_width == '0) begin
			w_eff = WB'(1);
		end else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(image_width);
		end
		if (image_height == '0) begin
			h_eff = HB'(1);
		end else if (CMPH'(image_height) > CMPH'(MAX_HEIGHT)) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(image_height);
		end
	end

	assign inr = (coord_x[COORD_BITS-1:FRAC_BITS] == '0) &&
	             (coord_y[COORD_BITS-1:FRAC_BITS] == '0);
	assign xs_prod = XB'(coord_x[FRAC_BITS-1:0]) * XB'(w_eff);
	assign ys_prod = YB'(coord_y[FRAC_BITS-1:0]) * YB'(h_eff);

	assign req_ready = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1   <= opcode;
			inr_s1  <= inr;
			addr_s1 <= pixel_address;
			data_s1 <= pixel_value;
			xs_s1   <= xs_prod;
			ys_s1   <= ys_prod;
		end
	end

	// neighbour columns and row bases, clamped at the right and lower edge
	assign c0        = xs_s1[XB-1:FRAC_BITS];
	assign c0p1      = c0 + WB'(1);
	assign c1        = (c0p1 < w_eff) ? c0p1 : c0;
	assign r0        = ys_s1[YB-1:FRAC_BITS];
	assign r0p1      = r0 + HB'(1);
	assign base_prod = RB'(r0) * RB'(w_eff);
	assign base0     = ADDR_BITS'(base_prod);
	assign base1     = (r0p1 < h_eff) ? base0 + ADDR_BITS'(w_eff) : base0;

	always_comb begin
		cmd.addr1  = base1;
		cmd.col0   = ADDR_BITS'(c0);
		cmd.col1   = ADDR_BITS'(c1);
		cmd.data   = data_s1;
		cmd.frac_x = xs_s1[FRAC_BITS-1:0];
		cmd.frac_y = ys_s1[FRAC_BITS-1:0];
		if (op_s1 == OP_WRITE) begin
			cmd.kind  = KIND_WRITE;
			cmd.addr0 = addr_s1;
		end else begin
			cmd.kind  = inr_s1 ? KIND_QUERY : KIND_ZERO;
			cmd.addr0 = base0;
		end
	end

endmodule

FILE: rtl/bis_back.sv
// bis_back: pixel store, neighbour read sequencer, blend datapath, result fifo
// depends on bis_pkg and bis_queue

module bis_back import bis_pkg::*; #(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_t                   cmd,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [RESULT_BITS-1:0] sample_value,
	output logic                   in_range,
	output bis_status_t            status
);

	localparam logic [1:0] NB_TL = 2'd0;
	localparam logic [1:0] NB_TR = 2'd1;
	localparam logic [1:0] NB_BL = 2'd2;
	localparam logic [1:0] NB_BR = 2'd3;

	localparam int WTB = FRAC_BITS + 1;
	localparam int HW  = PIXEL_BITS + FRAC_BITS;
	localparam int VW  = PIXEL_BITS + 2 * FRAC_BITS;
	localparam logic [WTB-1:0] ONE_W = WTB'(1) << FRAC_BITS;
	localparam logic [VW-1:0]  HALF  = VW'(1) << (FRAC_BITS - 1);

	logic [PIXEL_BITS-1:0] store [STORE_DEPTH];

	logic                   busy_q;
	logic [1:0]             step_q;
	cmd_t                   cur_q;
	logic [CREDIT_BITS-1:0] credit_q;

	logic                   cmd_pop, pop_write, pop_token;
	logic                   mem_we, mem_re;
	logic [ADDR_BITS-1:0]   mem_addr;
	logic                   tok_valid, tok_zero;
	logic [1:0]             tok_nb;
	logic [FRAC_BITS-1:0]   tok_fx, tok_fy;

	logic                   tok_s1, zero_s1;
	logic [1:0]             nb_s1;
	logic [FRAC_BITS-1:0]   fx_s1, fy_s1;
	logic [PIXEL_BITS-1:0]  pix_s1;
	logic                   fin_s2, zero_s2;
	logic [FRAC_BITS-1:0]   fy_s2;
	logic                   done_s3, zero_s3;

	logic [HW-1:0]          h_q;
	logic [VW-1:0]          v_q;
	logic [WTB-1:0]         h_wt, v_wt;
	logic [HW:0]            h_prod;
	logic [VW:0]            v_prod;
	logic [VW-1:0]          v_round;
	logic [RESULT_BITS-1:0] blend;
	logic                   res_push_ready;
	logic                   res_pop;

	// pop a command once the reads of the previous query are all issued and, for a query, a result credit is free
	assign pop_write = (cmd.kind == KIND_WRITE);
	assign cmd_ready = !busy_q && (pop_write || credit_q < CREDIT_BITS'(OUT_DEPTH));
	assign cmd_pop   = cmd_valid && cmd_ready;
	assign pop_token = cmd_pop && !pop_write;
	assign res_pop   = res_valid && res_ready;

	assign status.busy     = busy_q;
	assign status.pop      = cmd_pop;
	assign status.credits  = credit_q;
	// credits keep the result fifo from overflowing
	assign status.overflow = done_s3 && !res_push_ready;

	// single memory port: one write or one neighbour read per cycle
	always_comb begin
		mem_we = cmd_pop && pop_write;
		mem_re = busy_q || (cmd_pop && cmd.kind == KIND_QUERY);
		if (busy_q) begin
			case (step_q)
				NB_TR:   mem_addr = cur_q.addr0 + cur_q.col1;
				NB_BL:   mem_addr = cur_q.addr1 + cur_q.col0;
				default: mem_addr = cur_q.addr1 + cur_q.col1;
			endcase
		end else if (pop_write) begin
			mem_addr = cmd.addr0;
		end else begin
			mem_addr = cmd.addr0 + cmd.col0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_addr] <= cmd.data[PIXEL_BITS-1:0];
		end else if (mem_re) begin
			pix_s1 <= store[mem_addr];
		end
	end

	always_comb begin
		tok_valid = busy_q || pop_token;
		tok_zero  = !busy_q && (cmd.kind == KIND_ZERO);
		if (busy_q) begin
			tok_nb = step_q;
			tok_fx = cur_q.frac_x;
			tok_fy = cur_q.frac_y;
		end else begin
			tok_nb = tok_zero ? NB_BR : NB_TL;
			tok_fx = cmd.frac_x;
			tok_fy = cmd.frac_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= NB_TL;
			credit_q <= '0;
			tok_s1   <= 1'b0;
			fin_s2   <= 1'b0;
			done_s3  <= 1'b0;
		end else begin
			if (busy_q) begin
				if (step_q == NB_BR) begin
					busy_q <= 1'b0;
				end
				step_q <= step_q + 2'd1;
			end else if (cmd_pop && cmd.kind == KIND_QUERY) begin
				busy_q <= 1'b1;
				step_q <= NB_TR;
			end
			case ({pop_token, res_pop})
				2'b10:   credit_q <= credit_q + CREDIT_BITS'(1);
				2'b01:   credit_q <= credit_q - CREDIT_BITS'(1);
				default: credit_q <= credit_q;
			endcase
			tok_s1  <= tok_valid;
			fin_s2  <= tok_s1 && (nb_s1 == NB_BR);
			done_s3 <= fin_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		nb_s1   <= tok_nb;
		zero_s1 <= tok_zero;
		fx_s1   <= tok_fx;
		fy_s1   <= tok_fy;
		zero_s2 <= zero_s1;
		fy_s2   <= fy_s1;
		zero_s3 <= zero_s2;
	end

	// horizontal blend per row, then vertical blend of the two rows
	assign h_wt   = (nb_s1 == NB_TL || nb_s1 == NB_BL) ? ONE_W - WTB'(fx_s1) : WTB'(fx_s1);
	assign h_prod = (HW + 1)'(h_wt) * (HW + 1)'(pix_s1);
	assign v_wt   = fin_s2 ? WTB'(fy_s2) : ONE_W - WTB'(fy_s1);
	assign v_prod = (VW + 1)'(v_wt) * (VW + 1)'(h_q);

	always_ff @(posedge clk) begin
		if (tok_s1 && !zero_s1) begin
			case (nb_s1)
				NB_TL, NB_BL: h_q <= HW'(h_prod);
				default:      h_q <= h_q + HW'(h_prod);
			endcase
		end
		if (fin_s2 && !zero_s2) begin
			v_q <= v_q + VW'(v_prod);
		end else if (tok_s1 && !zero_s1 && nb_s1 == NB_BL) begin
			v_q <= VW'(v_prod);
		end
	end

	// round half up to q16.16
	assign v_round = v_q + HALF;
	assign blend   = zero_s3 ? '0 : RESULT_BITS'(v_round[VW-1:FRAC_BITS]);

	bis_queue #(
		.DATA_BITS (RESULT_BITS + 1),
		.DEPTH     (OUT_DEPTH)
	) u_res_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (done_s3),
		.push_ready (res_push_ready),
		.push_data  ({blend, !zero_s3}),
		.pop_valid  (res_valid),
		.pop_ready  (res_ready),
		.pop_data   ({sample_value, in_range})
	);

endmodule

FILE: rtl/bilinear_image_sampler.sv
// bilinear_image_sampler: top level with configuration registers
// depends on bis_pkg, bis_front, bis_queue and bis_back

// A request either writes one pixel (opcode 0) into the 65536-entry pixel
// store or queries a bilinear sample (opcode 1) at normalized coordinates
// given as signed fixed point with 16 fraction bits. A query returns one
// result, an unsigned Q16.16 gray level rounded half up, with in_range set
// when both coordinates lie in [0,1); otherwise the result is 0 with in_range
// clear. A write returns nothing. At the last column or row the right or
// lower neighbour is clamped to the edge pixel. Pixels must be written before
// a query reads them; the store has no reset. image_width and image_height
// (register 0 and 1) are used limited to 1..MAX_WIDTH and 1..MAX_HEIGHT and
// may only be changed while the block is idle. The front end takes one request
// per cycle, while the command queue has room, into a single register stage
// of scaling and a four-entry command queue. The back end does a write as one
// store access, an out-of-range query with no store read, and an in-range
// query as four neighbour reads through the single port of the pixel store,
// taking no command while those reads are issued. Results are returned in
// request order through a two-entry result fifo.

module bilinear_image_sampler import bis_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_data,
	// request channel
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         opcode,
	input  logic [ADDR_BITS-1:0]         pixel_address,
	input  logic [VALUE_BITS-1:0]        pixel_value,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	// result channel
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [RESULT_BITS-1:0]       sample_value,
	output logic                         in_range
);

	logic [CFG_BITS-1:0] width_q;
	logic [CFG_BITS-1:0] height_q;

	// front to queue
	logic        fq_valid, fq_ready;
	cmd_t        fq_cmd;
	// queue to back
	logic        qb_valid, qb_ready;
	cmd_t        qb_cmd;
	bis_status_t back_status;

	// configuration registers; the user must write them only while idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_SIZE_RESET;
			height_q <= CFG_SIZE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	// front end: scales coordinates, computes neighbour columns, row bases and fractions
	bis_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.image_width   (width_q),
		.image_height  (height_q),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.opcode        (opcode),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.cmd_valid     (fq_valid),
		.cmd_ready     (fq_ready),
		.cmd           (fq_cmd)
	);

	// command queue decouples the scaler from the memory sequencer
	bis_queue #(
		.DATA_BITS ($bits(cmd_t)),
		.DEPTH     (CMD_DEPTH)
	) u_cmd_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_cmd)
	);

	// back end: pixel store, neighbour reads, blend and result fifo
	bis_back #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (qb_valid),
		.cmd_ready    (qb_ready),
		.cmd          (qb_cmd),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.sample_value (sample_value),
		.in_range     (in_range),
		.status       (back_status)
	);

	// an out-of-range result always carries a zero sample
	a_zero_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !in_range |-> sample_value == '0)
		else $error("out-of-range result with nonzero sample");

	// outstanding result credits never exceed the result fifo depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.credits <= CREDIT_BITS'(OUT_DEPTH))
		else $error("result credits exceed fifo depth");

	// a pending result is always covered by a credit
	a_result_credit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> back_status.credits != '0)
		else $error("result present without credit");

	// no command is taken while neighbour reads are still being issued
	a_busy_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.busy |-> !back_status.pop)
		else $error("command popped while sequencer busy");

	// a finished result always finds room in the result fifo
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!back_status.overflow)
		else $error("result fifo full when a result completed");

endmodule

FILE: verif/bilinear_image_sampler_tb.sv
// bilinear_image_sampler_tb: self-checking testbench for the bilinear image sampler
// sends pixel writes and sample queries, predicts every sample, checks results in order
// depends on bis_pkg and bilinear_image_sampler

module bilinear_image_sampler_tb;
	import bis_pkg::*;

	localparam int STALL_LIMIT  = 4000;  // cycles with no accepted request or result
	localparam int DRAIN_CYCLES = 24;    // trailing writes still in flight after last result
	localparam int HOLD_CYCLES  = 300;   // long result back-pressure stretch
	localparam int HOLD_AFTER   = 200;   // requests accepted before the stretch starts

	typedef struct {
		logic                  op;
		logic [ADDR_BITS-1:0]  addr;
		logic [VALUE_BITS-1:0] value;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} sampler_req_t;

	typedef struct {
		logic [RESULT_BITS-1:0] value;
		logic                   in_range;
	} sample_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0]    cfg_index = REG_WIDTH;
	logic [CFG_BITS-1:0]          cfg_data = '0;
	logic                         req_valid = 1'b0;
	logic                         req_ready;
	logic                         opcode = OP_WRITE;
	logic [ADDR_BITS-1:0]         pixel_address = '0;
	logic [VALUE_BITS-1:0]        pixel_value = '0;
	logic signed [COORD_BITS-1:0] coord_x = '0;
	logic signed [COORD_BITS-1:0] coord_y = '0;
	logic                         res_valid;
	logic                         res_ready = 1'b0;
	logic [RESULT_BITS-1:0]       sample_value;
	logic                         in_range;

	// predictor state: image contents and raw size registers
	logic [VALUE_BITS-1:0] pixel_mem [STORE_DEPTH];
	logic [CFG_BITS-1:0]   width_reg = CFG_SIZE_RESET;
	logic [CFG_BITS-1:0]   height_reg = CFG_SIZE_RESET;

	// generator bookkeeping: which store entries will have been written
	bit                    written [STORE_DEPTH];

	sampler_req_t pending_requests[$];
	sample_t      expected_samples[$];
	int           items_left = 0;
	int           req_count = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           quiet_cycles = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;

	// a stretch of the run with no idling on either side
	wire calm = (cycle_count >= 1500) && (cycle_count < 2700);

	bilinear_image_sampler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.opcode       (opcode),
		.pixel_address(pixel_address),
		.pixel_value  (pixel_value),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.sample_value (sample_value),
		.in_range     (in_range)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// register value as the block uses it: zero acts as one, large values cap
	function automatic int unsigned size_in_use(input logic [CFG_BITS-1:0] raw,
			input int unsigned maxv);
		if (raw == 0)
			return 1;
		if (raw > maxv)
			return maxv;
		return 32'(raw);
	endfunction

	// the four neighbour addresses (upper left, upper right, lower left, lower right)
	// and the Q0.16 fractions of an in-range coordinate pair
	function automatic void neighbour_addrs(input logic [COORD_BITS-1:0] cx,
			input logic [COORD_BITS-1:0] cy, input int unsigned w, input int unsigned h,
			output logic [3:0][ADDR_BITS-1:0] addrs, output longint unsigned fx,
			output longint unsigned fy);
		int unsigned xs, ys, c0, r0, c1, r1;
		xs = cx[FRAC_BITS-1:0] * w;
		ys = cy[FRAC_BITS-1:0] * h;
		c0 = xs >> FRAC_BITS;
		r0 = ys >> FRAC_BITS;
		fx = 64'(xs & 32'hFFFF);
		fy = 64'(ys & 32'hFFFF);
		// clamp to the edge at the last column or row
		c1 = (c0 + 1 < w) ? c0 + 1 : c0;
		r1 = (r0 + 1 < h) ? r0 + 1 : r0;
		addrs[0] = ADDR_BITS'(c0 + r0 * w);
		addrs[1] = ADDR_BITS'(c1 + r0 * w);
		addrs[2] = ADDR_BITS'(c0 + r1 * w);
		addrs[3] = ADDR_BITS'(c1 + r1 * w);
	endfunction

	// bilinear blend with exact weights, rounded half up to Q16.16
	function automatic sample_t interpolate(input logic [COORD_BITS-1:0] cx,
			input logic [COORD_BITS-1:0] cy);
		sample_t s;
		logic [3:0][ADDR_BITS-1:0] addrs;
		longint unsigned fx, fy, gx, gy, acc;
		s.value = '0;
		s.in_range = 1'b0;
		if (cx[17:16] == 2'b00 && cy[17:16] == 2'b00) begin
			neighbour_addrs(cx, cy, size_in_use(width_reg, DEF_MAX_WIDTH),
				size_in_use(height_reg, DEF_MAX_HEIGHT), addrs, fx, fy);
			gx = 64'd65536 - fx;
			gy = 64'd65536 - fy;
			acc = gx * gy * pixel_mem[addrs[0]] + fx * gy * pixel_mem[addrs[1]]
				+ gx * fy * pixel_mem[addrs[2]] + fx * fy * pixel_mem[addrs[3]];
			s.value = RESULT_BITS'((acc + 64'd32768) >> 16);
			s.in_range = 1'b1;
		end
		return s;
	endfunction

	// gray level with the extremes favored
	function automatic logic [VALUE_BITS-1:0] random_level();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return VALUE_BITS'($urandom);
	endfunction

	// in-range coordinate with the ends of [0,1) favored
	function automatic logic [COORD_BITS-1:0] random_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 18'h0FFFF;
		return {2'b00, 16'($urandom)};
	endfunction

	task automatic push_write(input logic [ADDR_BITS-1:0] addr,
			input logic [VALUE_BITS-1:0] value);
		sampler_req_t item;
		item.op = OP_WRITE;
		item.addr = addr;
		item.value = value;
		item.x = COORD_BITS'($urandom);   // ignored on a write
		item.y = COORD_BITS'($urandom);
		pending_requests.push_back(item);
		written[addr] = 1'b1;
		items_left++;
	endtask

	// a query is preceded by writes of any neighbour that was never written
	task automatic push_query(input logic [COORD_BITS-1:0] cx,
			input logic [COORD_BITS-1:0] cy);
		sampler_req_t item;
		logic [3:0][ADDR_BITS-1:0] addrs;
		longint unsigned fx, fy;
		if (cx[17:16] == 2'b00 && cy[17:16] == 2'b00) begin
			neighbour_addrs(cx, cy, size_in_use(width_reg, DEF_MAX_WIDTH),
				size_in_use(height_reg, DEF_MAX_HEIGHT), addrs, fx, fy);
			for (int i = 0; i < 4; i++)
				if (!written[addrs[i]])
					push_write(addrs[i], random_level());
		end
		item.op = OP_QUERY;
		item.addr = ADDR_BITS'($urandom);   // ignored on a query
		item.value = VALUE_BITS'($urandom);
		item.x = cx;
		item.y = cy;
		pending_requests.push_back(item);
		items_left++;
	endtask

	task automatic random_phase(input int count);
		int unsigned r, span;
		logic [COORD_BITS-1:0] cx, cy;
		span = size_in_use(width_reg, DEF_MAX_WIDTH) * size_in_use(height_reg, DEF_MAX_HEIGHT);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				push_query(random_coord(), random_coord());
			end else if (r < 75) begin
				// at least one coordinate outside [0,1)
				cx = COORD_BITS'($urandom);
				cy = COORD_BITS'($urandom);
				if (cx[17:16] == 2'b00 && cy[17:16] == 2'b00) begin
					if ($urandom_range(0, 1))
						cx[17] = 1'b1;
					else
						cy[16] = 1'b1;
				end
				push_query(cx, cy);
			end else if (r < 90) begin
				push_write(ADDR_BITS'($urandom_range(0, span - 1)), random_level());
			end else begin
				push_write(ADDR_BITS'($urandom), random_level());
			end
		end
	endtask

	// wait for every request and result, then for trailing writes to settle
	task automatic wait_idle();
		while (items_left != 0 || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg = w;
		height_reg = h;
	endtask

	// stimulus: directed cases at reset size, then random phases over several sizes
	// (neighbour fill writes roughly double the random item counts below)
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of address and gray level
		push_write(16'hFFFF, 16'hFFFF);
		push_write(16'h0000, 16'h0000);
		// corners, last column and last row clamp
		push_query(18'h00000, 18'h00000);
		push_query(18'h0FFFF, 18'h0FFFF);
		push_query(18'h0FFFF, 18'h00000);
		push_query(18'h00000, 18'h0FFFF);
		push_query(18'h08000, 18'h08080);
		// coordinates at 1.0, negative, and the field extremes
		push_query(18'h10000, 18'h00000);
		push_query(18'h00000, 18'h10000);
		push_query(18'h3FFFF, 18'h00000);
		push_query(18'h00000, 18'h3FFFF);
		push_query(18'h20000, 18'h1FFFF);
		push_query(18'h1FFFF, 18'h20000);

		random_phase(120);
		wait_idle();
		set_size(9'd3, 9'd2);
		random_phase(200);
		wait_idle();
		set_size(9'd0, 9'd0);       // both act as one
		random_phase(80);
		wait_idle();
		set_size(9'd511, 9'd257);   // both cap at the maximum
		random_phase(80);
		wait_idle();
		set_size(9'd256, 9'd1);
		random_phase(100);
		wait_idle();
		set_size(9'd1, 9'd256);
		random_phase(100);
		wait_idle();
		set_size(9'($urandom_range(2, 255)), 9'($urandom_range(2, 255)));
		random_phase(100);
		wait_idle();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// request driver: valid holds with a steady payload until accepted
	always @(posedge clk) begin
		sampler_req_t nxt;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (opcode == OP_WRITE)
					pixel_mem[pixel_address] = pixel_value;
				else
					expected_samples.push_back(interpolate(coord_x, coord_y));
				items_left--;
				req_count <= req_count + 1;
			end
			if (!req_valid || req_ready) begin
				if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
					nxt = pending_requests.pop_front();
					req_valid <= 1'b1;
					opcode <= nxt.op;
					pixel_address <= nxt.addr;
					pixel_value <= nxt.value;
					coord_x <= nxt.x;
					coord_y <= nxt.y;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		sample_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: result with no query waiting, got sample_value %h in_range %b",
						$time, sample_value, in_range);
					mismatch_count++;
				end else begin
					want = expected_samples.pop_front();
					if (sample_value !== want.value) begin
						$display("%0t: sample_value mismatch, expected %h, got %h",
							$time, want.value, sample_value);
						mismatch_count++;
					end
					if (in_range !== want.in_range) begin
						$display("%0t: in_range mismatch, expected %b, got %b",
							$time, want.in_range, in_range);
						mismatch_count++;
					end
				end
			end
			// one long hold so the block fills and stalls requests
			if (!hold_done && req_count >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= calm || ($urandom_range(0, 99) >= 7);
			end
		end
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ((req_valid && req_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
